[rtl/core/gpg_pkg.sv]
// Shared types and constants of the polar Gaussian generator.
package gpg_pkg;

  localparam int V_BITS  = 31;   // |V| in Q.30, up to 1.0
  localparam int S_BITS  = 60;   // S in Q.60, below 1.0 when kept
  localparam int Q_DEPTH = 4;    // front-to-back queue entries

  // 2 ln 2 in Q1.26
  localparam logic [26:0] TWO_LN2_Q26 = 27'd93032640;

  // configuration register indexes
  localparam logic [1:0] REG_MEAN = 2'd0;
  localparam logic [1:0] REG_STD  = 2'd1;

  typedef struct packed {
    logic              n1;
    logic [V_BITS-1:0] m1;
    logic              n2;
    logic [V_BITS-1:0] m2;
  } side_t;

  typedef struct packed {
    side_t             v;
    logic [S_BITS-1:0] s;
  } pair_t;

endpackage

[rtl/core/gaussian_polar_generator.sv]
// Marsaglia polar Gaussian generator top level: config registers, front, queue, back.
//
// Each request on the input channel is one pair of uniform samples. The pair
// is mapped to V1, V2 in [-1, 1] and S = V1^2 + V2^2; pairs with S >= 1 or
// S == 0 are dropped silently, and every kept pair yields two output requests,
// mean + std * V * sqrt(-2 ln S / S), V1 first (last=0) then V2 (last=1).
// Mean and sample are signed Q11.12, deviation is unsigned Q4.12; results
// saturate to 24 bits. The input side takes one pair per clock while the queue
// has room. The front registers the input, does the exact division by
// 2^UNIFORM_BITS - 1 in two steps of adds and shifts, then the square and sum;
// the back holds the 30 squaring stages of the log, the 32-stage root of
// -2 ln S and the 33-stage divider for V*r/q. The output side gives one sample
// per clock while out_ready is high, and the back end does not advance to the
// next kept pair until both samples of the current one are taken; a 4-entry
// queue sits between front and back.
// Configuration writes take effect at once and should be made while the block
// is idle.
module gaussian_polar_generator #(
  parameter int UNIFORM_BITS = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  // pair input
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic [UNIFORM_BITS-1:0] uniform_a,
  input  logic [UNIFORM_BITS-1:0] uniform_b,
  // sample output
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [23:0]             sample,
  output logic                    last,
  // register writes
  input  logic                    cfg_valid,
  output logic                    cfg_ready,
  input  logic [1:0]              cfg_index,
  input  logic [23:0]             cfg_data
);

  logic [23:0]    mean_value;
  logic [15:0]    std_deviation;

  logic           q_push, q_ready, q_valid, q_pop;
  gpg_pkg::pair_t q_wdata, q_rdata;

  // registers are always writable; unknown indexes are ignored
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      mean_value    <= 24'd0;
      std_deviation <= 16'd4096;
    end else if (cfg_valid) begin
      case (cfg_index)
        gpg_pkg::REG_MEAN: mean_value    <= cfg_data;
        gpg_pkg::REG_STD:  std_deviation <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  // front: V1, V2, S and the reject test
  gpg_front #(.UB(UNIFORM_BITS)) u_front (
    .clk(clk), .rst(rst),
    .uniform_a(uniform_a), .uniform_b(uniform_b),
    .in_valid(in_valid), .in_ready(in_ready),
    .push(q_push), .q_ready(q_ready), .pdata(q_wdata)
  );

  // decoupling queue for kept pairs
  gpg_queue u_queue (
    .clk(clk), .rst(rst),
    .push(q_push), .wdata(q_wdata), .ready(q_ready),
    .valid(q_valid), .rdata(q_rdata), .pop(q_pop)
  );

  // back: log, roots, divide, scale and output serializer
  gpg_back u_back (
    .clk(clk), .rst(rst),
    .q_valid(q_valid), .q_data(q_rdata), .q_pop(q_pop),
    .mean_value(mean_value), .std_deviation(std_deviation),
    .out_valid(out_valid), .out_ready(out_ready),
    .sample(sample), .last(last)
  );

  // first sample of a pair is always followed by its partner
  a_pair_order: assert property (@(posedge clk) disable iff (rst)
    (out_valid && out_ready && !last) |=> (out_valid && last))
    else $error("second sample of pair missing");

  // back never pops an empty queue
  a_no_underflow: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> q_valid)
    else $error("queue popped while empty");

  // input stalls only when the queue is full
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    !in_ready |-> !q_ready)
    else $error("input stalled with queue space free");

endmodule

[rtl/core/gpg_div.sv]
// Pipelined restoring divider, one quotient bit per stage.
module gpg_div #(
  parameter int NW = 62,
  parameter int DW = 31,
  parameter int QW = 31
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QW-1:0] quo
);

  localparam int W = ((NW > DW + QW) ? NW : DW + QW) + 1;

  logic [W-1:0]  rem [0:QW];
  logic [DW-1:0] dd  [0:QW];
  logic [QW-1:0] qq  [0:QW];

  assign rem[0] = W'(num);
  assign dd[0]  = den;
  assign qq[0]  = '0;

  for (genvar j = 0; j < QW; j++) begin : g_stage
    localparam int B = QW - 1 - j;
    logic [W-1:0] cand;
    assign cand = W'(dd[j]) << B;
    always_ff @(posedge clk) begin
      if (en) begin
        dd[j+1] <= dd[j];
        if (rem[j] >= cand) begin
          rem[j+1] <= rem[j] - cand;
          qq[j+1]  <= qq[j] | (QW'(1'b1) << B);
        end else begin
          rem[j+1] <= rem[j];
          qq[j+1]  <= qq[j];
        end
      end
    end
  end

  assign quo = qq[QW];

endmodule

[rtl/core/gpg_sqrt.sv]
// Pipelined integer square root, one root bit per stage.
module gpg_sqrt #(
  parameter int IW = 60
) (
  input  logic                  clk,
  input  logic                  en,
  input  logic [IW-1:0]         x,
  output logic [(IW+1)/2-1:0]   root
);

  localparam int RW = (IW + 1) / 2;
  localparam int W  = 2 * RW + 2;

  logic [W-1:0]  rem [0:RW];
  logic [RW-1:0] rt  [0:RW];

  assign rem[0] = W'(x);
  assign rt[0]  = '0;

  for (genvar j = 0; j < RW; j++) begin : g_stage
    localparam int B = RW - 1 - j;
    logic [W-1:0] cand;
    // (P + 2^B)^2 - P^2
    assign cand = (W'(rt[j]) << (B + 1)) + (W'(1'b1) << (2 * B));
    always_ff @(posedge clk) begin
      if (en) begin
        if (rem[j] >= cand) begin
          rem[j+1] <= rem[j] - cand;
          rt[j+1]  <= rt[j] | (RW'(1'b1) << B);
        end else begin
          rem[j+1] <= rem[j];
          rt[j+1]  <= rt[j];
        end
      end
    end
  end

  assign root = rt[RW];

endmodule

[rtl/core/gpg_front.sv]
// Front end: takes uniform pairs, forms V1, V2 and S, drops rejected pairs.
module gpg_front #(
  parameter int UB = 16
) (
  input  logic            clk,
  input  logic            rst,
  input  logic [UB-1:0]   uniform_a,
  input  logic [UB-1:0]   uniform_b,
  input  logic            in_valid,
  output logic            in_ready,
  output logic            push,
  input  logic            q_ready,
  output gpg_pkg::pair_t  pdata
);

  localparam int VB  = gpg_pkg::V_BITS;
  localparam int NW  = UB + 30;
  localparam int ND  = (NW + UB - 1) / UB;   // UB-bit digits in a numerator
  localparam int LAT = 1 + 2 + 2;   // input reg, remainder, quotient, square, sum
  localparam logic [UB-1:0] SPAN = {UB{1'b1}};
  localparam logic [UB-1:0] HALF = SPAN >> 1;

  // n mod M from the sum of UB-bit digits, since 2^UB = 1 mod M
  function automatic logic [UB-1:0] mod_span(logic [NW-1:0] n);
    logic [UB+2:0] acc;
    logic [UB:0]   fold;
    acc = '0;
    for (int i = 0; i < ND; i++) begin
      acc = acc + (UB+3)'((n >> (i * UB)) & NW'(SPAN));
    end
    fold = (UB+1)'(acc[UB-1:0]) + (UB+1)'(acc[UB+2:UB]);
    if (fold >= (UB+1)'(SPAN)) fold = fold - (UB+1)'(SPAN);
    return fold[UB-1:0];
  endfunction

  // exact (n - r) / M as a product with the inverse of M modulo 2^VB
  function automatic logic [VB-1:0] div_span(logic [NW-1:0] n, logic [UB-1:0] r);
    logic [VB-1:0] x, acc;
    x   = VB'(n - NW'(r));
    acc = '0;
    for (int i = 0; i * UB < VB; i++) begin
      acc = acc + (x << (i * UB));
    end
    return VB'(0) - acc;
  endfunction

  logic           en;
  logic [LAT:1]   vld;
  logic [LAT:1]   na_line, nb_line;
  logic [UB-1:0]  mag_a, mag_b;
  logic [UB:0]    two_a, two_b;
  logic [NW-1:0]  num_a, num_b, n_a, n_b;
  logic [UB-1:0]  r_a, r_b;
  logic [VB-1:0]  qa, qb, sqa_m, sqb_m;
  logic [61:0]    sq_a, sq_b, ssum;
  logic           keep;
  logic [59:0]    s_fin;
  logic [VB-1:0]  ma_fin, mb_fin;

  assign two_a = {uniform_a, 1'b0};
  assign two_b = {uniform_b, 1'b0};

  // whole pipe moves unless the last item is kept and the queue is full
  assign en       = ~vld[LAT] | ~keep | q_ready;
  assign in_ready = en;
  assign push     = vld[LAT] & keep & q_ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (en) begin
      vld <= {vld[LAT-1:1], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      na_line <= {na_line[LAT-1:1], (two_a < (UB+1)'(SPAN))};
      nb_line <= {nb_line[LAT-1:1], (two_b < (UB+1)'(SPAN))};
      mag_a   <= (two_a < (UB+1)'(SPAN)) ? UB'((UB+1)'(SPAN) - two_a)
                                         : UB'(two_a - (UB+1)'(SPAN));
      mag_b   <= (two_b < (UB+1)'(SPAN)) ? UB'((UB+1)'(SPAN) - two_b)
                                         : UB'(two_b - (UB+1)'(SPAN));
    end
  end

  // |V| = round(|2u - M| * 2^30 / M): remainder first, then the exact quotient
  assign num_a = {mag_a, 30'b0} + NW'(HALF);
  assign num_b = {mag_b, 30'b0} + NW'(HALF);

  always_ff @(posedge clk) begin
    if (en) begin
      n_a <= num_a;
      n_b <= num_b;
      r_a <= mod_span(num_a);
      r_b <= mod_span(num_b);
      qa  <= div_span(n_a, r_a);
      qb  <= div_span(n_b, r_b);
    end
  end

  assign ssum = sq_a + sq_b;

  always_ff @(posedge clk) begin
    if (en) begin
      sq_a   <= qa * qa;
      sq_b   <= qb * qb;
      sqa_m  <= qa;
      sqb_m  <= qb;
      keep   <= (ssum != '0) && (ssum[61:60] == 2'b00);
      s_fin  <= ssum[59:0];
      ma_fin <= sqa_m;
      mb_fin <= sqb_m;
    end
  end

  assign pdata.v.n1 = na_line[LAT];
  assign pdata.v.m1 = ma_fin;
  assign pdata.v.n2 = nb_line[LAT];
  assign pdata.v.m2 = mb_fin;
  assign pdata.s    = s_fin;

endmodule

[rtl/core/gpg_queue.sv]
// Small FIFO between the front and back ends.
module gpg_queue (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  gpg_pkg::pair_t wdata,
  output logic           ready,
  output logic           valid,
  output gpg_pkg::pair_t rdata,
  input  logic           pop
);

  localparam int D  = gpg_pkg::Q_DEPTH;
  localparam int PW = $clog2(D);

  gpg_pkg::pair_t mem [0:D-1];
  logic [PW-1:0]  wp, rp;
  logic [PW:0]    cnt;

  assign ready = cnt != (PW+1)'(D);
  assign valid = cnt != '0;
  assign rdata = mem[rp];

  always_ff @(posedge clk) begin
    if (rst) begin
      wp  <= '0;
      rp  <= '0;
      cnt <= '0;
    end else begin
      if (push) wp <= wp + PW'(1);
      if (pop)  rp <= rp + PW'(1);
      cnt <= cnt + (PW+1)'(push) - (PW+1)'(pop);
    end
  end

  always_ff @(posedge clk) begin
    if (push) mem[wp] <= wdata;
  end

endmodule

[rtl/core/gpg_back.sv]
// Back end: -2 ln S, square roots, scaling and the two-sample output.
module gpg_back (
  input  logic           clk,
  input  logic           rst,
  input  logic           q_valid,
  input  gpg_pkg::pair_t q_data,
  output logic           q_pop,
  input  logic [23:0]    mean_value,
  input  logic [15:0]    std_deviation,
  output logic           out_valid,
  input  logic           out_ready,
  output logic [23:0]    sample,
  output logic           last
);

  localparam int LOG_LAT = 35;             // t registered here
  localparam int R_AT    = LOG_LAT + 32;   // sqrt(t) done
  localparam int Q_AT    = 30;             // sqrt(S) done
  localparam int MUL_AT  = R_AT + 1;
  localparam int Z_AT    = MUL_AT + 33;
  localparam int YM_AT   = Z_AT + 1;
  localparam int LAST    = YM_AT + 1;

  function automatic logic [5:0] top_bit(logic [59:0] x);
    logic [5:0] e;
    e = '0;
    for (int i = 0; i < 60; i++) begin
      if (x[i]) e = 6'(i);
    end
    return e;
  endfunction

  function automatic logic [23:0] finish(logic neg, logic [48:0] ym, logic [23:0] mean);
    logic [49:0] rs;
    logic [25:0] y;
    rs = {1'b0, ym} + (50'd1 << 27);
    y  = neg ? {{2{mean[23]}}, mean} - 26'(rs[49:28])
             : {{2{mean[23]}}, mean} + 26'(rs[49:28]);
    if (y[25:23] == 3'b000 || y[25:23] == 3'b111) return y[23:0];
    return y[25] ? 24'h800000 : 24'h7FFFFF;
  endfunction

  logic                en, phase;
  logic [LAST:1]       vld;
  gpg_pkg::side_t      sd [1:YM_AT];

  assign en        = ~vld[LAST] | (out_ready & phase);
  assign q_pop     = en & q_valid;
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld   <= '0;
      phase <= 1'b0;
    end else begin
      if (en) vld <= {vld[LAST-1:1], q_valid};
      if (out_valid && out_ready) phase <= ~phase;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      sd[1] <= q_data.v;
      for (int k = 2; k <= YM_AT; k++) sd[k] <= sd[k-1];
    end
  end

  // ---- -log2(S): normalize, then 30 squarings ----
  logic [59:0] s_a, s_sh;
  logic [5:0]  e_a, e_b;
  logic [31:0] m_b;
  logic [63:0] pr [1:30];
  logic [29:0] fr [1:30];
  logic [5:0]  ex [1:30];

  assign s_sh = s_a << (6'd59 - e_a);

  always_ff @(posedge clk) begin
    if (en) begin
      s_a <= q_data.s;
      e_a <= top_bit(q_data.s);
      m_b <= s_sh[59:28];
      e_b <= e_a;
    end
  end

  for (genvar k = 1; k <= 30; k++) begin : g_sq
    logic [31:0] msel;
    if (k == 1) begin : g_first
      assign msel = m_b;
      always_ff @(posedge clk) begin
        if (en) begin
          pr[k] <= msel * msel;
          ex[k] <= e_b;
          fr[k] <= '0;
        end
      end
    end else begin : g_next
      assign msel = pr[k-1][63] ? pr[k-1][63:32] : pr[k-1][62:31];
      always_ff @(posedge clk) begin
        if (en) begin
          pr[k] <= msel * msel;
          ex[k] <= ex[k-1];
          fr[k] <= {fr[k-1][28:0], pr[k-1][63]};
        end
      end
    end
  end

  // ---- t = -2 ln S ----
  logic [35:0] nl;
  logic [44:0] ph, pl;
  logic [63:0] tsum;
  logic [36:0] t;
  logic [31:0] r;

  assign tsum = 64'({ph, 18'b0}) + 64'(pl) + (64'd1 << 25);

  always_ff @(posedge clk) begin
    if (en) begin
      nl <= {6'd60 - ex[30], 30'b0} - 36'({fr[30][28:0], pr[30][63]});
      ph <= nl[35:18] * gpg_pkg::TWO_LN2_Q26;
      pl <= nl[17:0] * gpg_pkg::TWO_LN2_Q26;
      t  <= tsum[62:26];
    end
  end

  gpg_sqrt #(.IW(63)) u_rsqrt (.clk(clk), .en(en), .x({t, 26'b0}), .root(r));

  // ---- sqrt(S), delayed to line up with r ----
  logic [29:0] qr;
  logic [29:0] qd [Q_AT+1:R_AT];

  gpg_sqrt #(.IW(60)) u_qsqrt (.clk(clk), .en(en), .x(q_data.s), .root(qr));

  always_ff @(posedge clk) begin
    if (en) begin
      qd[Q_AT+1] <= qr;
      for (int k = Q_AT + 2; k <= R_AT; k++) qd[k] <= qd[k-1];
    end
  end

  // ---- z = |V| * r / q ----
  logic [62:0] p1, p2;
  logic [29:0] qm;
  logic [32:0] z1, z2;

  always_ff @(posedge clk) begin
    if (en) begin
      p1 <= sd[R_AT].m1 * r;
      p2 <= sd[R_AT].m2 * r;
      qm <= qd[R_AT];
    end
  end

  gpg_div #(.NW(63), .DW(30), .QW(33)) u_zdiv1 (
    .clk(clk), .en(en), .num(p1 + 63'(qm >> 1)), .den(qm), .quo(z1)
  );
  gpg_div #(.NW(63), .DW(30), .QW(33)) u_zdiv2 (
    .clk(clk), .en(en), .num(p2 + 63'(qm >> 1)), .den(qm), .quo(z2)
  );

  // ---- scale, offset, saturate ----
  logic [48:0] ym1, ym2;
  logic [23:0] y1, y2;

  always_ff @(posedge clk) begin
    if (en) begin
      ym1 <= z1 * std_deviation;
      ym2 <= z2 * std_deviation;
      y1  <= finish(sd[YM_AT].n1, ym1, mean_value);
      y2  <= finish(sd[YM_AT].n2, ym2, mean_value);
    end
  end

  assign sample = phase ? y2 : y1;
  assign last   = phase;

endmodule
